>>> sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// types and constants shared by the slot table front end, queue and back end
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam int COUNT_W     = 7;
   localparam int INDEX_W     = 32;
   localparam int WORD_W      = 32;
   localparam int DIV_STEPS   = INDEX_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int REQ_FIELD_W = 2 + INDEX_W + WORD_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 1 + 1 + WORD_W + 1 + WORD_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_TAKE  = 2'd1,
      OP_PEEK  = 2'd2
   } op_type;

   typedef enum logic {
      CSR_SLOT_COUNT = 1'b0,
      CSR_OVERWRITE  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_EXEC
   } back_state_type;

   // reduced request handed from the front end to the back end
   typedef struct packed {
      op_type               op;
      logic [COUNT_W-1:0]   slot;
      logic [WORD_W-1:0]    value;
   } entry_type;

   // result fields, last field in the lowest bits
   typedef struct packed {
      logic [COUNT_W-1:0]   occupancy;
      logic [WORD_W-1:0]    evicted_value;
      logic                 evicted;
      logic [WORD_W-1:0]    data;
      logic                 present;
      logic                 accepted;
   } rsp_type;

endpackage

>>> sv/ist_front.sv
// ----------------------------------------------------------------------------
// ist_front
// accepts requests and reduces the index modulo the slot count, one bit a cycle
// ----------------------------------------------------------------------------
module ist_front import ist_pkg::*; #(
   parameter int MAX_COUNT = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_op,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [WORD_W-1:0]   req_value,
   input  logic [COUNT_W-1:0]  slot_count,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_COUNT);

   front_state_type     state_ff, state_in;
   logic [INDEX_W-1:0]  dvd_ff, dvd_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   op_type              op_ff, op_in;
   logic [WORD_W-1:0]   value_ff, value_in;
   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W:0]    trial;
   logic [COUNT_W:0]    trial_sub;

   always_comb begin
      if (slot_count == '0) begin
         eff_count = COUNT_W'(1);
      end else if (slot_count > MAX_N) begin
         eff_count = MAX_N;
      end else begin
         eff_count = slot_count;
      end
   end

   assign trial     = {rem_ff, dvd_ff[INDEX_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in   = state_ff;
      dvd_in     = dvd_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      req_tready = 1'b0;
      q_push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dvd_in   = req_index;
               div_in   = eff_count;
               rem_in   = '0;
               cnt_in   = STEP_W'(DIV_STEPS - 1);
               op_in    = op_type'(req_op);
               value_in = req_value;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            dvd_in = {dvd_ff[INDEX_W-2:0], 1'b0};
            if (trial >= {1'b0, div_ff}) begin
               rem_in = trial_sub[COUNT_W-1:0];
            end else begin
               rem_in = trial[COUNT_W-1:0];
            end
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            q_push = 1'b1;
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign q_entry.op    = op_ff;
   assign q_entry.slot  = rem_ff;
   assign q_entry.value = value_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_DIV) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
`endif

endmodule

>>> sv/ist_queue.sv
// ----------------------------------------------------------------------------
// ist_queue
// two-entry queue between the index reduction and the table access
// ----------------------------------------------------------------------------
module ist_queue import ist_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output entry_type  head_entry
);

   entry_type    slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

>>> sv/ist_back.sv
// ----------------------------------------------------------------------------
// ist_back
// slot table access: valid marks, data memory, occupancy and result register
// ----------------------------------------------------------------------------
module ist_back import ist_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       overwrite_enable,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output rsp_type    rsp
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   back_state_type          state_ff, state_in;
   logic [DATA_WIDTH-1:0]   slot_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0]   rd_data_ff;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [COUNT_W-1:0]      occ_ff, occ_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [IDX_W-1:0]        idx;
   logic                    had;
   logic [WORD_W-1:0]       old;
   logic                    mem_re;
   logic                    mem_we;

   assign idx = head_entry.slot[IDX_W-1:0];
   assign had = valid_ff[idx];
   assign old = had ? WORD_W'(rd_data_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         valid_ff      <= '0;
         occ_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_store_ff[idx] <= DATA_WIDTH'(head_entry.value);
      end
      if (mem_re) begin
         rd_data_ff <= slot_store_ff[idx];
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      pop           = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (head_valid && (!rsp_tvalid_ff || rsp_tready)) begin
               mem_re   = 1'b1;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            pop           = 1'b1;
            rsp_tvalid_in = 1'b1;
            state_in      = B_IDLE;
            rsp_in        = '0;
            unique case (head_entry.op)
               OP_STORE: begin
                  rsp_in.present = had;
                  if (!had) begin
                     mem_we          = 1'b1;
                     valid_in[idx]   = 1'b1;
                     occ_in          = occ_ff + COUNT_W'(1);
                     rsp_in.accepted = 1'b1;
                  end else if (overwrite_enable) begin
                     mem_we               = 1'b1;
                     rsp_in.accepted      = 1'b1;
                     rsp_in.evicted       = 1'b1;
                     rsp_in.evicted_value = old;
                  end
               end
               OP_TAKE: begin
                  rsp_in.accepted = 1'b1;
                  rsp_in.present  = had;
                  rsp_in.data     = old;
                  if (had) begin
                     valid_in[idx] = 1'b0;
                     occ_in        = occ_ff - COUNT_W'(1);
                  end
               end
               OP_PEEK: begin
                  rsp_in.accepted = 1'b1;
                  rsp_in.present  = had;
                  rsp_in.data     = old;
               end
               default: begin
               end
            endcase
            rsp_in.occupancy = occ_in;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp        = rsp_ff;

`ifndef SYNTHESIS
   a_occ_matches_marks: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(valid_ff))
      else $error("occupancy out of step with valid marks");
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EXEC) |=> (state_ff == B_IDLE) && rsp_tvalid_ff)
      else $error("table access did not produce an item");
   a_exec_has_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EXEC) |-> head_valid)
      else $error("table access without a queued entry");
`endif

endmodule

>>> sv/indexed_slot_table.sv
// ----------------------------------------------------------------------------
// indexed_slot_table
// direct-mapped slot table with store, take and peek on a reduced index
// ----------------------------------------------------------------------------
// A new request item is taken only once the previous one has been handed on:
// an accept state, the bit-serial remainder unit that reduces the 32-bit index
// modulo the slot count, and a push state that hands the reduced request to the
// table and waits while the queue is full. The table side adds a memory read,
// then update and result register, which overlap the next reduction. Slot
// counts of zero act as one; counts above the table size saturate.
// Only min(SLOTS, 127) slots are built, since the 7-bit count cannot reach more.
module indexed_slot_table import ist_pkg::*; #(
   parameter int SLOTS      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // op [1:0], index [33:2], value [65:34]
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // accepted [0], present [1], data [33:2], evicted [34],
   // evicted_value [66:35], occupancy [73:67]
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [COUNT_W-1:0]      csr_wdata
);

   localparam int MAX_ADDR = (1 << COUNT_W) - 1;
   localparam int DEPTH    = (SLOTS < MAX_ADDR) ? SLOTS : MAX_ADDR;

   logic [COUNT_W-1:0]  slot_count_ff;
   logic                overwrite_ff;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   entry_type           q_in_entry;
   entry_type           q_head;
   rsp_type             rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_W'(64);
         overwrite_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLOT_COUNT: slot_count_ff <= csr_wdata;
            CSR_OVERWRITE:  overwrite_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ist_front #(
      .MAX_COUNT (DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[1:0]),
      .req_index  (req_tdata[2 +: INDEX_W]),
      .req_value  (req_tdata[2 + INDEX_W +: WORD_W]),
      .slot_count (slot_count_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_in_entry)
   );

   ist_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   ist_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .overwrite_enable (overwrite_ff),
      .head_valid       (q_valid),
      .head_entry       (q_head),
      .pop              (q_pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp              (rsp)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, rsp};

endmodule
